>>> src/sync_length_crc_frame_receiver_assert.svh
// Assertion macros for the sync/length/CRC frame receiver.
// Needs nothing; included by the top level only.
`ifndef SYNC_LENGTH_CRC_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_CRC_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SLCRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SLCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/slcrc_pkg.sv
// Shared types and constants for the sync/length/CRC frame receiver.
// No dependencies.
package slcrc_pkg;

  localparam logic [7:0]  SyncFirst     = 8'hFE;
  localparam logic [7:0]  SyncSecond    = 8'hFF;
  localparam logic [15:0] CrcPoly       = 16'h1021;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [8:0]  FrameOverhead = 9'd7;

  localparam logic [8:0]  CountHunt     = 9'd0;
  localparam logic [8:0]  CountSync     = 9'd1;
  localparam logic [8:0]  CountCmdLow   = 9'd3;
  localparam logic [8:0]  CountCmdHigh  = 9'd4;
  localparam logic [8:0]  CountLength   = 9'd5;
  localparam logic [8:0]  CountCrcHigh  = 9'd6;

  typedef enum logic {
    KindPayload  = 1'b0,
    KindFrameEnd = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] command;
    logic [7:0]  payload_length;
    logic        crc_good;
  } result_t;

  typedef struct packed {
    logic       in_valid;
    logic       advance;
    logic       frame_end;
    logic [8:0] count;
    logic [7:0] length;
  } parser_status_t;

endpackage

>>> src/sync_length_crc_frame_receiver.sv
// Sync/length/CRC frame receiver, top level.
// Each input byte is registered in the parser's input register, parsed combinationally,
// and any result it yields is loaded into the output register, which presents the result transaction.
// Throughput: one byte per cycle while the output is not stalled; the input register drains
// in the same cycle as the result register frees, and the CRC step is one byte per cycle.
// Reset (rst_ni, async, active low): hunting for sync, CRC at 0xFFFF, both empty.
`include "sync_length_crc_frame_receiver_assert.svh"
module sync_length_crc_frame_receiver import slcrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  byte_index_o,
  output logic [15:0] command_o,
  output logic [7:0]  payload_length_o,
  output logic        crc_good_o
);

  logic           in_ready;
  logic           out_ready;
  logic           res_valid;
  result_t        res;
  result_t        res_out;
  parser_status_t status;

  slcrc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte_i),
    .out_ready_i (out_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  slcrc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (status.advance && res_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (res_out)
  );

  assign in_stall_o       = !in_ready;
  assign kind_o           = res_out.kind;
  assign data_byte_o      = res_out.data_byte;
  assign byte_index_o     = res_out.byte_index;
  assign command_o        = res_out.command;
  assign payload_length_o = res_out.payload_length;
  assign crc_good_o       = res_out.crc_good;

  `SLCRC_ASSERT_IMP(a_stall_needs_byte, clk_i, rst_ni, in_stall_o, status.in_valid, "stall without held byte")
  `SLCRC_ASSERT_IMP(a_count_in_frame, clk_i, rst_ni, status.count > CountLength, status.count < {1'b0, status.length} + FrameOverhead, "byte count past frame end")
  `SLCRC_ASSERT_IMP(a_payload_fields, clk_i, rst_ni, out_valid_o && kind_o == KindPayload, !crc_good_o && byte_index_o < payload_length_o, "bad payload result")
  `SLCRC_ASSERT_NEXT(a_end_rehunts, clk_i, rst_ni, status.advance && status.frame_end, status.count == CountHunt, "no hunt after frame end")

endmodule

>>> src/slcrc_crc.sv
// One-byte CRC-16/CCITT-FALSE update, MSB first.
// Depends on slcrc_pkg.
module slcrc_crc import slcrc_pkg::*; (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

>>> src/slcrc_parser.sv
// Input register and frame state: sync hunt, header, payload, CRC check.
// Depends on slcrc_pkg and slcrc_crc.
module slcrc_parser import slcrc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           out_ready_i,
  output logic           res_valid_o,
  output result_t        res_o,
  output parser_status_t status_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic [8:0]  count_q, count_d;
  logic [15:0] cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] crc_next;
  logic [8:0]  n;
  logic [8:0]  n_index;
  logic        advance;
  logic        frame_end;

  slcrc_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_q),
    .crc_o  (crc_next)
  );

  assign n       = count_q + 9'd1;
  assign n_index = n - CountCrcHigh;

  always_comb begin
    count_d   = count_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    crc_d     = crc_q;
    hi_d      = hi_q;
    frame_end = 1'b0;
    res_valid_o          = 1'b0;
    res_o.kind           = KindPayload;
    res_o.data_byte      = 8'h00;
    res_o.byte_index     = 8'h00;
    res_o.command        = cmd_q;
    res_o.payload_length = len_q;
    res_o.crc_good       = 1'b0;
    if (in_valid_q) begin
      priority if (count_q == CountHunt) begin
        if (byte_q == SyncFirst) count_d = CountSync;
      end else if (count_q == CountSync) begin
        priority if (byte_q == SyncSecond) count_d = CountSync + 9'd1;
        else if (byte_q == SyncFirst)      count_d = CountSync;
        else                               count_d = CountHunt;
      end else begin
        count_d = n;
        priority if (n == CountCmdLow) begin
          cmd_d = {8'h00, byte_q};
        end else if (n == CountCmdHigh) begin
          cmd_d = {byte_q, cmd_q[7:0]};
        end else if (n == CountLength) begin
          len_d = byte_q;
          crc_d = CrcInit;
        end else if (n <= {1'b0, len_q} + CountLength) begin
          crc_d            = crc_next;
          res_valid_o      = 1'b1;
          res_o.data_byte  = byte_q;
          res_o.byte_index = n_index[7:0];
        end else if (n == {1'b0, len_q} + CountCrcHigh) begin
          hi_d = byte_q;
        end else begin
          frame_end      = 1'b1;
          res_valid_o    = 1'b1;
          res_o.kind     = KindFrameEnd;
          res_o.crc_good = ({hi_q, byte_q} == crc_q);
          count_d        = CountHunt;
        end
      end
    end
  end

  assign advance    = in_valid_q && (!res_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      count_q    <= CountHunt;
      cmd_q      <= 16'h0000;
      len_q      <= 8'h00;
      crc_q      <= CrcInit;
      hi_q       <= 8'h00;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        count_q <= count_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        crc_q   <= crc_d;
        hi_q    <= hi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) byte_q <= in_byte_i;
  end

  assign status_o.in_valid  = in_valid_q;
  assign status_o.advance   = advance;
  assign status_o.frame_end = frame_end;
  assign status_o.count     = count_q;
  assign status_o.length    = len_q;

endmodule

>>> src/slcrc_out_reg.sv
// Result register: holds one result transaction until the sink takes it.
// Depends on slcrc_pkg.
module slcrc_out_reg import slcrc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> tb/sync_length_crc_frame_receiver_checker.sv
// Checker for the sync/length/CRC frame receiver: watches both channels, predicts
// the result transactions from the input bytes and compares them in order.
// Depends on slcrc_pkg; reports its failure and outstanding counts to the testbench top.
module sync_length_crc_frame_receiver_checker import slcrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  byte_index_i,
  input  logic [15:0] command_i,
  input  logic [7:0]  payload_length_i,
  input  logic        crc_good_i,
  output int          pending_o,
  output int          failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [8:0]  frame_pos;
  logic [15:0] cmd_word;
  logic [7:0]  frame_len;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi;
  result_t     expected_results[$];
  int          fail_count;

  assign failures_o = fail_count;

  function automatic logic [15:0] crc_after_byte(logic [15:0] crc, logic [7:0] b);
    crc = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      crc = crc[15] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
    end
    return crc;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    result_t    r;
    logic [8:0] n;
    r = '0;
    if (frame_pos == CountHunt) begin
      if (b == SyncFirst) frame_pos = CountSync;
    end else if (frame_pos == CountSync) begin
      if (b == SyncSecond) frame_pos = CountSync + 9'd1;
      else if (b == SyncFirst) frame_pos = CountSync;
      else frame_pos = CountHunt;
    end else begin
      n = frame_pos + 9'd1;
      frame_pos = n;
      if (n == CountCmdLow) begin
        cmd_word = {8'h00, b};
      end else if (n == CountCmdHigh) begin
        cmd_word[15:8] = b;
      end else if (n == CountLength) begin
        frame_len = b;
        crc_acc = CrcInit;
      end else if (n <= CountLength + 9'(frame_len)) begin
        crc_acc = crc_after_byte(crc_acc, b);
        r.kind = KindPayload;
        r.data_byte = b;
        r.byte_index = 8'(n - CountCrcHigh);
        r.command = cmd_word;
        r.payload_length = frame_len;
        expected_results.insert(expected_results.size(), r);
      end else if (n == CountCrcHigh + 9'(frame_len)) begin
        crc_hi = b;
      end else begin
        r.kind = KindFrameEnd;
        r.command = cmd_word;
        r.payload_length = frame_len;
        r.crc_good = ({crc_hi, b} == crc_acc);
        expected_results.insert(expected_results.size(), r);
        frame_pos = CountHunt;
      end
    end
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      frame_pos = CountHunt;
      cmd_word = '0;
      frame_len = '0;
      crc_acc = CrcInit;
      crc_hi = '0;
      expected_results.delete();
      fail_count = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with none expected: expected none, actual kind %0d",
                   $time, kind_i);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          report_field("kind", want.kind, kind_i);
          report_field("data_byte", want.data_byte, data_byte_i);
          report_field("byte_index", want.byte_index, byte_index_i);
          report_field("command", want.command, command_i);
          report_field("payload_length", want.payload_length, payload_length_i);
          report_field("crc_good", want.crc_good, crc_good_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_byte(in_byte_i);
      pending_o = expected_results.size();
    end
  end

endmodule

>>> tb/sync_length_crc_frame_receiver_tb.sv
// Testbench top for the sync/length/CRC frame receiver: clock, reset, byte stimulus,
// random output stalls, watchdog and verdict.
// Depends on slcrc_pkg, the block and sync_length_crc_frame_receiver_checker.
module sync_length_crc_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slcrc_pkg::*;

  localparam int NumItems   = 1450;
  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [15:0] command;
  logic [7:0]  payload_length;
  logic        crc_good;
  int          pending;
  int          failures;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;

  sync_length_crc_frame_receiver DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_byte_i       (in_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .data_byte_o     (data_byte),
    .byte_index_o    (byte_index),
    .command_o       (command),
    .payload_length_o(payload_length),
    .crc_good_o      (crc_good)
  );

  sync_length_crc_frame_receiver_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_byte_i       (in_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .kind_i          (kind),
    .data_byte_i     (data_byte),
    .byte_index_i    (byte_index),
    .command_i       (command),
    .payload_length_i(payload_length),
    .crc_good_i      (crc_good),
    .pending_o       (pending),
    .failures_o      (failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
    crc = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      crc = crc[15] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
    end
    return crc;
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return SyncFirst;
      2: return SyncSecond;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] rand_command();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] rand_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(0, 8));
    if (r < 90) return 8'($urandom_range(9, 40));
    return 8'($urandom_range(41, 100));
  endfunction

  // Returns at the rising edge that accepted the transaction; valid stays high.
  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    if (counted) items_sent++;
  endtask

  task automatic send_frame(input logic [15:0] cmd, input logic [7:0] len, input bit bad_crc);
    logic [15:0] crc;
    logic [7:0]  p;
    crc = CrcInit;
    send_byte(SyncFirst, 1'b1);
    send_byte(SyncSecond, 1'b1);
    send_byte(cmd[7:0], 1'b1);
    send_byte(cmd[15:8], 1'b1);
    send_byte(len, 1'b1);
    for (int i = 0; i < int'(len); i++) begin
      p = payload_byte();
      crc = crc_next(crc, p);
      send_byte(p, 1'b1);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    send_byte(crc[15:8], 1'b1);
    send_byte(crc[7:0], 1'b1);
  endtask

  task automatic drain_pause();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int  run_left;
    bit  stall_now;
    bit  hold_done;
    run_left = 0;
    stall_now = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_now = 1'b1;
        run_left = HoldCycles;
      end else if (run_left == 0) begin
        stall_now = ($urandom_range(0, 2) == 0);
        run_left = stall_now ? gap_len() : $urandom_range(1, 40);
      end
      out_stall <= stall_now;
      run_left--;
    end
  end

  initial begin
    int         frame_no;
    int         sel;
    logic [7:0] b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // noise, bad second sync byte, restart on a repeated first sync byte
    send_byte(8'h00, 1'b1);
    send_byte(SyncFirst, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(SyncFirst, 1'b1);
    send_frame(16'h0000, 8'd0, 1'b0);
    send_frame(16'hFFFF, 8'd1, 1'b0);
    send_frame(16'h0100, 8'd0, 1'b1);
    drain_pause();

    frame_no = 0;
    while (items_sent < NumItems) begin
      sel = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (frame_no == 4) begin
        hold_req = 1'b1;
        no_gaps = 1'b1;
        send_frame(rand_command(), 8'd60, 1'b0);
      end else if (frame_no == 7) begin
        send_frame(rand_command(), 8'd255, 1'b0);
      end else if (frame_no % 100 == 50) begin
        drain_pause();
      end else if (sel < 8) begin
        repeat ($urandom_range(1, 5)) begin
          b = 8'($urandom_range(0, 255));
          if (b == SyncFirst || b == SyncSecond) b = 8'h55;
          send_byte(b, 1'b0);
        end
      end else if (sel < 14) begin
        send_byte(SyncFirst, 1'b1);
        b = 8'($urandom_range(0, 255));
        if (b == SyncSecond) b = 8'h00;
        send_byte(b, 1'b1);
      end else begin
        send_frame(rand_command(), rand_length(), $urandom_range(0, 9) == 0);
      end
      frame_no++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
